### rtl/core/spiral_index_to_coordinate_core_assert.svh
// ----------------------------------------------------------------------------
// Spiral locator assertion macros
// Shared property forms for the checkers of the spiral locator.
// ----------------------------------------------------------------------------
`ifndef SPIRAL_INDEX_TO_COORDINATE_CORE_ASSERT_SVH
`define SPIRAL_INDEX_TO_COORDINATE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SITC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SITC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sitc_pkg.sv
// ----------------------------------------------------------------------------
// Spiral locator package
// Shared widths, defaults, codes and control types of the spiral locator.
// ----------------------------------------------------------------------------
package sitc_pkg;

  localparam int unsigned CFG_W            = 9;
  localparam int unsigned TARGET_W         = 17;
  localparam int unsigned COORD_W          = 8;
  localparam int unsigned S_TDATA_W        = 24;
  localparam int unsigned M_TDATA_W        = 16;
  localparam int unsigned MAX_SIDE_DEFAULT = 256;
  localparam logic [CFG_W-1:0] SIDE_RESET  = 9'd1;

  // Operation of the shared subtract unit
  typedef enum logic [0:0] {
    OP_RING_STEP = 1'b0,  // square of the next inner ring
    OP_OFFSET    = 1'b1   // distance of the target from the ring start
  } arith_op_e;

  typedef struct packed {
    logic busy;
    logic done;
    logic in_range;
  } walk_status_t;

endpackage

### rtl/core/sitc_arith_unit.sv
// ----------------------------------------------------------------------------
// Spiral locator shared subtract unit
// One subtractor with operand select, reused every cycle of the walk.
// ----------------------------------------------------------------------------
module sitc_arith_unit #(
  parameter int unsigned SideW = 9,
  parameter int unsigned CmpW  = 18
) (
  input  sitc_pkg::arith_op_e                  op_i,
  input  logic [CmpW-1:0]                      square_i,
  input  logic [SideW-1:0]                     side_i,
  input  logic [sitc_pkg::TARGET_W-1:0]        target_i,
  output logic [CmpW-1:0]                      diff_o,
  output logic                                 covers_o
);

  logic [CmpW-1:0] sub_b;

  always_comb begin
    case (op_i)
      sitc_pkg::OP_RING_STEP: sub_b = CmpW'({(side_i - SideW'(1)), 2'b00});
      sitc_pkg::OP_OFFSET:    sub_b = CmpW'(target_i);
      default:                sub_b = '0;
    endcase
  end

  // (m-2)^2 = m^2 - 4(m-1); the inner ring still covers the target when it
  // is not below it
  assign diff_o   = square_i - sub_b;
  assign covers_o = (diff_o >= CmpW'(target_i));

endmodule

### rtl/core/sitc_side_decode.sv
// ----------------------------------------------------------------------------
// Spiral locator side decode
// Maps ring side, ring index and offset to row and column.
// ----------------------------------------------------------------------------
module sitc_side_decode #(
  parameter int unsigned SideW = 9
) (
  input  logic [SideW-1:0] ring_side_i,
  input  logic [SideW-1:0] ring_index_i,
  input  logic [SideW+1:0] offset_i,
  output logic [SideW-1:0] row_o,
  output logic [SideW-1:0] col_o
);

  localparam int unsigned W = SideW + 2;

  logic [W-1:0] mm;
  logic [W-1:0] kk;
  logic [W-1:0] far;
  logic [W-1:0] r;
  logic [W-1:0] c;

  assign mm  = W'(ring_side_i);
  assign kk  = W'(ring_index_i);
  assign far = kk + mm - W'(1);

  always_comb begin
    if (offset_i < mm) begin
      // top edge, walking left
      r = kk;
      c = far - offset_i;
    end else if (offset_i < (mm + mm - W'(1))) begin
      // left edge, walking down
      r = kk + offset_i - (mm - W'(1));
      c = kk;
    end else if (offset_i < (mm + mm + mm - W'(2))) begin
      // bottom edge, walking right
      r = far;
      c = kk + offset_i - (mm + mm - W'(2));
    end else begin
      // right edge, walking up
      r = far - (offset_i - (mm + mm + mm - W'(3)));
      c = far;
    end
  end

  assign row_o = r[SideW-1:0];
  assign col_o = c[SideW-1:0];

endmodule

### rtl/core/sitc_ring_walk.sv
// ----------------------------------------------------------------------------
// Spiral locator ring walk
// Sequencer that steps inward ring by ring through the shared subtractor.
// ----------------------------------------------------------------------------
module sitc_ring_walk #(
  parameter int unsigned MaxSide = sitc_pkg::MAX_SIDE_DEFAULT,
  parameter int unsigned SideW   = $clog2(MaxSide + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              ack_i,
  input  logic [sitc_pkg::CFG_W-1:0]        side_cfg_i,
  input  logic [sitc_pkg::TARGET_W-1:0]     target_i,
  output sitc_pkg::walk_status_t            status_o,
  output logic [SideW-1:0]                  ring_side_o,
  output logic [SideW-1:0]                  ring_index_o,
  output logic [SideW+1:0]                  offset_o
);

  localparam int unsigned SqW  = 2 * SideW;
  localparam int unsigned CmpW = (SqW > sitc_pkg::TARGET_W) ? SqW : sitc_pkg::TARGET_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_WALK  = 5'b00100,
    ST_DIFF  = 5'b01000,
    ST_DONE  = 5'b10000
  } walk_state_e;

  walk_state_e                       state_q, state_d;
  logic [SideW-1:0]                  n_q, n_d;
  logic [sitc_pkg::TARGET_W-1:0]     s_q, s_d;
  logic [SideW-1:0]                  m_q, m_d;
  logic [CmpW-1:0]                   sq_q, sq_d;
  logic [SideW+1:0]                  d_q, d_d;
  logic [SideW-1:0]                  k_q, k_d;
  logic                              in_range_q, in_range_d;

  logic [SideW-1:0]                  side_clamped;
  logic [SqW-1:0]                    full_square;
  logic                              out_of_range;
  sitc_pkg::arith_op_e               op;
  logic [CmpW-1:0]                   diff;
  logic                              covers;

  assign side_clamped = (32'(side_cfg_i) > 32'(MaxSide)) ? SideW'(MaxSide)
                                                          : SideW'(side_cfg_i);
  assign full_square  = SqW'(n_q) * SqW'(n_q);
  assign out_of_range = (s_q == '0) || (n_q == '0) || (CmpW'(s_q) > CmpW'(full_square));

  assign op = (state_q == ST_DIFF) ? sitc_pkg::OP_OFFSET : sitc_pkg::OP_RING_STEP;

  sitc_arith_unit #(
    .SideW (SideW),
    .CmpW  (CmpW)
  ) u_arith (
    .op_i     (op),
    .square_i (sq_q),
    .side_i   (m_q),
    .target_i (s_q),
    .diff_o   (diff),
    .covers_o (covers)
  );

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    s_d        = s_q;
    m_d        = m_q;
    sq_d       = sq_q;
    d_d        = d_q;
    k_d        = k_q;
    in_range_d = in_range_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          n_d     = side_clamped;
          s_d     = target_i;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        m_d  = n_q;
        sq_d = CmpW'(full_square);
        if (out_of_range) begin
          in_range_d = 1'b0;
          state_d    = ST_DONE;
        end else begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if ((CmpW'(m_q) > CmpW'(2)) && covers) begin
          m_d  = m_q - SideW'(2);
          sq_d = diff;
        end else begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        d_d        = diff[SideW+1:0];
        k_d        = (n_q - m_q) >> 1;
        in_range_d = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (ack_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      in_range_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      in_range_q <= in_range_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q  <= n_d;
    s_q  <= s_d;
    m_q  <= m_d;
    sq_q <= sq_d;
    d_q  <= d_d;
    k_q  <= k_d;
  end

  assign status_o.busy     = (state_q != ST_IDLE);
  assign status_o.done     = (state_q == ST_DONE);
  assign status_o.in_range = in_range_q;
  assign ring_side_o       = m_q;
  assign ring_index_o      = k_q;
  assign offset_o          = d_q;

endmodule

### rtl/core/spiral_index_to_coordinate_core.sv
// ----------------------------------------------------------------------------
// Spiral index to coordinate core
// Finds the row and column of a cell number in a counterclockwise spiral grid.
// ----------------------------------------------------------------------------
// The grid is grid_side cells square (capped at MaxSide) and numbered from
// n*n in the top-right corner down to 1, running left, down, right, up and
// inward. Each input transaction carries a cell number; each output
// transaction returns its row and column with in_range set, or zeros with
// in_range clear when the number is 0 or above n*n. A transaction passes
// through a setup state, the ring walk, an offset state and a done state,
// where it waits until the output register is free; an out-of-range number
// goes from setup straight to done. The ring walk steps one ring inward per
// cycle through a single shared subtractor. The input side takes a new
// transaction as soon as the walk is idle, even while the previous result
// still waits in the output register. Write grid_side only while the block
// is idle.
// ----------------------------------------------------------------------------
module spiral_index_to_coordinate_core #(
  parameter int unsigned MaxSide = sitc_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration: grid_side
  input  logic                              cfg_wen_i,
  input  logic [sitc_pkg::CFG_W-1:0]        cfg_wdata_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [sitc_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // [16:0] target_number
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [sitc_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // [7:0] row, [15:8] column
  output logic                              m_axis_tuser   // [0] in_range
);

  localparam int unsigned SideW = $clog2(MaxSide + 1);

  logic [sitc_pkg::CFG_W-1:0]     side_q;
  sitc_pkg::walk_status_t         status;
  logic [SideW-1:0]               ring_side;
  logic [SideW-1:0]               ring_index;
  logic [SideW+1:0]               offset;
  logic [SideW-1:0]               row;
  logic [SideW-1:0]               col;
  logic                           start;
  logic                           load;

  logic                           out_valid_q;
  logic [sitc_pkg::COORD_W-1:0]   row_q, row_d;
  logic [sitc_pkg::COORD_W-1:0]   col_q, col_d;
  logic                           in_range_q;

  // Configuration register, written with no handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= sitc_pkg::SIDE_RESET;
    end else if (cfg_wen_i) begin
      side_q <= cfg_wdata_i;
    end
  end

  // Accept a new transaction whenever the walk sequencer is idle
  assign s_axis_tready = !status.busy;
  assign start         = s_axis_tvalid && s_axis_tready;

  sitc_ring_walk #(
    .MaxSide (MaxSide),
    .SideW   (SideW)
  ) u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .ack_i        (load),
    .side_cfg_i   (side_q),
    .target_i     (s_axis_tdata[sitc_pkg::TARGET_W-1:0]),
    .status_o     (status),
    .ring_side_o  (ring_side),
    .ring_index_o (ring_index),
    .offset_o     (offset)
  );

  sitc_side_decode #(
    .SideW (SideW)
  ) u_decode (
    .ring_side_i  (ring_side),
    .ring_index_i (ring_index),
    .offset_i     (offset),
    .row_o        (row),
    .col_o        (col)
  );

  // Move the finished result into the output register once it is free or
  // draining this cycle; drop the coordinates for an out-of-range number
  assign load  = status.done && (!out_valid_q || m_axis_tready);
  assign row_d = status.in_range ? sitc_pkg::COORD_W'(row) : '0;
  assign col_d = status.in_range ? sitc_pkg::COORD_W'(col) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the payload until the next result loads
  always_ff @(posedge clk_i) begin
    if (load) begin
      row_q      <= row_d;
      col_q      <= col_d;
      in_range_q <= status.in_range;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {col_q, row_q};
  assign m_axis_tuser  = in_range_q;

endmodule

### rtl/core/sitc_checker.sv
// ----------------------------------------------------------------------------
// Spiral locator port checker
// Watches the stream ports of the core over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "spiral_index_to_coordinate_core_assert.svh"

module sitc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [sitc_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);

  // A stalled result keeps its payload
  `SITC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // An out-of-range result carries zero coordinates
  `SITC_ASSERT_NOW(a_oor_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "out-of-range result with nonzero coordinates")

  // The walk is busy right after taking a transaction
  `SITC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready right after acceptance")

  // A result never shows up in the cycle right after acceptance
  `SITC_ASSERT_NOW(a_no_instant_result, clk_i, rst_ni, $rose(m_axis_tvalid), !$past(s_axis_tvalid && s_axis_tready), "result too early")

endmodule

bind spiral_index_to_coordinate_core sitc_checker u_sitc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
